// File: hdl/hsca_pkg.sv
// Shared types and constants of the histogram shift chi-square aligner.
`timescale 1ns / 1ps
package hsca_pkg;

  localparam int QUOT_BITS = 42;
  localparam int SUM_BITS = 43;
  localparam int WIN_BITS = 11;
  localparam logic [SUM_BITS-1:0] CHI_LIMIT = 43'd2559999999744;
  localparam logic [WIN_BITS-1:0] WIN_START_RST = 11'd1;
  localparam logic [WIN_BITS-1:0] WIN_END_RST = 11'd1024;
  localparam logic REG_WIN_START = 1'b0;
  localparam logic REG_WIN_END = 1'b1;

  typedef struct packed {
    logic [15:0] top_count;
    logic [15:0] bottom_count;
    logic        last_bin;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] best_shift;
    logic [41:0]       min_chi_square;
    logic              found;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic start;
    logic shift_init;
    logic rd;
    logic bin_next;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic acc;
    logic shift_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic shifts_done;
    logic bins_done;
    logic skip;
    logic sqrt_last;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/histogram_shift_chi2_aligner_core.sv
// Top level of the histogram shift chi-square aligner with its register port.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | hsca_pkg::in_word_t
//   out_    | output    | out_valid/out_stall | hsca_pkg::out_word_t
//   APB     | input     | psel/penable/pready | window_start_bin, window_end_bin
//
// A word without the last-bin mark is taken without a stall; the last-bin word starts the search.
// Per shift, the search visits each bin of the window; for each pair with both counts nonzero
// it runs a bit-serial square root of RW = (COUNT_BITS + 32) / 2 steps, rounded up, and a
// 42-step divider.
// Reset is synchronous; the bin stores need no clearing pass.
// A result held by out_stall does not block loading of the next histogram or its search; only the next result waits.
`timescale 1ns / 1ps
module histogram_shift_chi2_aligner_core #(
  parameter int MAX_BINS = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsca_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsca_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [hsca_pkg::WIN_BITS-1:0] win_start_r, win_end_r;
  hsca_pkg::cmd_t cmd;
  hsca_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= hsca_pkg::WIN_START_RST;
      win_end_r <= hsca_pkg::WIN_END_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == hsca_pkg::REG_WIN_START) begin
        win_start_r <= pwdata[hsca_pkg::WIN_BITS-1:0];
      end else begin
        win_end_r <= pwdata[hsca_pkg::WIN_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == hsca_pkg::REG_WIN_END) ? 32'(win_end_r) : 32'(win_start_r);

  hsca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_bin),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  hsca_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .win_start (win_start_r),
    .win_end   (win_end_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hdl/hsca_ctrl.sv
// Sequencer that steps the datapath through loading and the shift search.
`timescale 1ns / 1ps
module hsca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  hsca_pkg::sts_t sts,
  output hsca_pkg::cmd_t cmd,
  output logic          in_stall
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_BIN, S_WAIT, S_SQRT, S_DIVI, S_DIV, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.shifts_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        if (sts.bins_done) begin
          cmd.shift_end = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.skip) begin
          cmd.bin_next = 1'b1;
          state_nxt = S_BIN;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.acc = 1'b1;
          state_nxt = S_BIN;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_CHECK && state_nxt == S_CHECK) begin
      state_nxt = S_CHECK;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: hdl/hsca_dp.sv
// Datapath: bin stores, window and shift counters, square root, divider and sums.
`timescale 1ns / 1ps
module hsca_dp #(
  parameter int MAX_BINS = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hsca_pkg::cmd_t                     cmd,
  output hsca_pkg::sts_t                     sts,
  input  hsca_pkg::in_word_t                 in_data,
  input  logic [hsca_pkg::WIN_BITS-1:0]      win_start,
  input  logic [hsca_pkg::WIN_BITS-1:0]      win_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output hsca_pkg::out_word_t                out_data
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int LW = $clog2(MAX_BINS + 1);
  localparam int CW = (AW + 4 > 13) ? AW + 4 : 13;
  localparam int VW = ((COUNT_BITS + 33) / 2) * 2;
  localparam int RW = VW / 2;
  localparam int PW = 2 * COUNT_BITS;
  localparam int DW = PW + 18;
  localparam int QW = hsca_pkg::QUOT_BITS;
  localparam int SW = hsca_pkg::SUM_BITS;
  localparam int NW = $clog2(QW);
  localparam logic signed [CW-1:0] ONE = signed'(CW'(1));

  logic [COUNT_BITS-1:0] ref_mem [MAX_BINS];
  logic [COUNT_BITS-1:0] shf_mem [MAX_BINS];

  logic [LW-1:0]         loaded_r;
  logic signed [CW-1:0]  n_r, h_r, lo_r, hi_r, s_r, bin_r;
  logic [COUNT_BITS-1:0] t_q, b_q;
  logic                  inr_q;
  logic [VW-1:0]         v_r;
  logic [RW+1:0]         rem_r;
  logic [RW-1:0]         root_r;
  logic [DW-1:0]         d2_r;
  logic [RW:0]           dr_r;
  logic [QW-1:0]         q_r;
  logic                  sat_r;
  logic [NW-1:0]         cnt_r;
  logic [SW-1:0]         sum_r, best_r;
  logic [7:0]            best_s_r;
  logic                  found_r;
  logic                  out_valid_r;
  hsca_pkg::out_word_t   out_r;

  logic                  has_room;
  logic [LW-1:0]         n_load;
  logic signed [CW-1:0]  n_s, ws_s, we_s, bin_m1, sb, sb_m1;
  logic [COUNT_BITS-1:0] dd;
  logic [PW-1:0]         dd_w, prod;
  logic [RW+1:0]         rem2, trial;
  logic                  sq_ge;
  logic [RW:0]           r2, dvs;
  logic                  dv_ge;
  logic [SW-1:0]         tmp_sum;

  assign has_room = (loaded_r < LW'(MAX_BINS));
  assign n_load = has_room ? loaded_r + 1'b1 : loaded_r;
  assign n_s = signed'(CW'(n_load));
  assign ws_s = signed'(CW'(win_start));
  assign we_s = signed'(CW'(win_end));
  assign bin_m1 = bin_r - ONE;
  assign sb = bin_r + s_r;
  assign sb_m1 = sb - ONE;

  assign dd = (b_q > t_q) ? b_q - t_q : t_q - b_q;
  assign dd_w = PW'(dd);
  assign prod = dd_w * dd_w;

  assign rem2 = {rem_r[RW-1:0], v_r[VW-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign sq_ge = (rem2 >= trial);

  assign dvs = {1'b0, root_r};
  assign r2 = {dr_r[RW-1:0], q_r[QW-1]};
  assign dv_ge = (r2 >= dvs);

  assign tmp_sum = sum_r + SW'({q_r[QW-2:0], dv_ge});

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      ref_mem[loaded_r[AW-1:0]] <= COUNT_BITS'(in_data.top_count);
      shf_mem[loaded_r[AW-1:0]] <= COUNT_BITS'(in_data.bottom_count);
    end
    if (cmd.rd) begin
      t_q <= ref_mem[bin_m1[AW-1:0]];
      b_q <= shf_mem[sb_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        loaded_r <= '0;
      end else if (cmd.load && has_room) begin
        loaded_r <= loaded_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r <= n_s;
      h_r <= n_s >>> 3;
      s_r <= -(n_s >>> 3);
      lo_r <= (ws_s == '0) ? ONE : ws_s;
      hi_r <= (we_s > n_s + ONE) ? n_s + ONE : we_s;
      found_r <= 1'b0;
      best_r <= '0;
      best_s_r <= '0;
    end
    if (cmd.shift_init) begin
      sum_r <= '0;
      bin_r <= lo_r;
    end
    if (cmd.rd) begin
      inr_q <= (sb >= ONE) && (sb <= n_r);
    end
    if (cmd.bin_next || cmd.acc) begin
      bin_r <= bin_r + ONE;
    end
    if (cmd.sqrt_init) begin
      v_r <= VW'({t_q, 32'b0});
      rem_r <= '0;
      root_r <= '0;
      cnt_r <= '0;
      d2_r <= DW'(prod);
    end
    if (cmd.sqrt_step) begin
      v_r <= v_r << 2;
      rem_r <= sq_ge ? rem2 - trial : rem2;
      root_r <= {root_r[RW-2:0], sq_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.div_init) begin
      sat_r <= ((d2_r >> 18) >= DW'(root_r));
      dr_r <= (RW + 1)'(d2_r >> 18);
      q_r <= {d2_r[17:0], (QW - 18)'(0)};
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dr_r <= dv_ge ? r2 - dvs : r2;
      q_r <= {q_r[QW-2:0], dv_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.acc) begin
      sum_r <= (sat_r || tmp_sum >= hsca_pkg::CHI_LIMIT) ? hsca_pkg::CHI_LIMIT : tmp_sum;
    end
    if (cmd.shift_end) begin
      if (sum_r < hsca_pkg::CHI_LIMIT && (!found_r || sum_r < best_r)) begin
        best_r <= sum_r;
        best_s_r <= s_r[7:0];
        found_r <= 1'b1;
      end
      s_r <= s_r + ONE;
    end
    if (cmd.finish) begin
      out_r.best_shift <= found_r ? signed'(best_s_r) : '0;
      out_r.min_chi_square <= found_r ? best_r[41:0] : '0;
      out_r.found <= found_r;
    end
  end

  assign sts.shifts_done = (s_r >= h_r);
  assign sts.bins_done = (bin_r >= hi_r);
  assign sts.skip = (t_q == '0) || (b_q == '0) || !inr_q;
  assign sts.sqrt_last = (cnt_r == NW'(RW - 1));
  assign sts.div_last = (cnt_r == NW'(QW - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// File: hdl/hsca_checker.sv
// Port-level checks of the aligner and their attachment to the top level.
`timescale 1ns / 1ps
module hsca_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hsca_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hsca_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed.");

  a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_bin |=> in_stall)
    else $error("Input taken while the shift search runs.");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.best_shift == '0 && out_data.min_chi_square == '0)
    else $error("Not-found result carries nonzero fields.");

  a_found_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> {1'b0, out_data.min_chi_square} < hsca_pkg::CHI_LIMIT)
    else $error("Reported sum is not below the limit.");

endmodule

bind histogram_shift_chi2_aligner_core hsca_checker u_hsca_checker (.*);

// File: verif/tb_histogram_shift_chi2_aligner_core.sv
// Self-checking testbench of the histogram shift chi-square aligner core.
`timescale 1ns / 1ps
module tb_histogram_shift_chi2_aligner_core;

  localparam int STORE_DEPTH = 1024;
  localparam longint unsigned CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  hsca_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  hsca_pkg::out_word_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  histogram_shift_chi2_aligner_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [15:0] top_bins[STORE_DEPTH];
  logic [15:0] bottom_bins[STORE_DEPTH];
  int loaded;
  logic [hsca_pkg::WIN_BITS-1:0] win_start;
  logic [hsca_pkg::WIN_BITS-1:0] win_end;
  hsca_pkg::out_word_t alignments_due[$];
  int errors;
  int words_sent;
  int results_seen;
  int hold_left;
  bit hold_go;
  bit no_idle;
  longint unsigned cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded cycle limit", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure, with an occasional long hold requested by a test.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      hold_left = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    hsca_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (alignments_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, out_data);
      end else begin
        want = alignments_due.pop_front();
        if (out_data.best_shift !== want.best_shift) begin
          errors++;
          $display("%0t: best_shift expected %0d actual %0d", $time,
                   want.best_shift, out_data.best_shift);
        end
        if (out_data.min_chi_square !== want.min_chi_square) begin
          errors++;
          $display("%0t: min_chi_square expected %0d actual %0d", $time,
                   want.min_chi_square, out_data.min_chi_square);
        end
        if (out_data.found !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_data.found);
        end
      end
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned chi_term(longint unsigned b, longint unsigned t);
    longint unsigned d;
    longint unsigned d2;
    longint unsigned sq;
    longint unsigned q;
    d = (b > t) ? b - t : t - b;
    d2 = d * d;
    sq = isqrt(t << 32);
    if (sq == 0) return hsca_pkg::CHI_LIMIT;
    q = d2 / sq;
    if (q >= (64'd1 << 18)) return hsca_pkg::CHI_LIMIT;
    return (q << 24) + (((d2 % sq) << 24) / sq);
  endfunction

  function automatic longint unsigned shift_cost(int s, int n);
    int lo;
    int hi;
    int sb;
    longint unsigned sum;
    longint unsigned t;
    longint unsigned b;
    lo = win_start;
    hi = win_end;
    sum = 0;
    if (lo < 1) lo = 1;
    if (hi > n + 1) hi = n + 1;
    for (int bin = lo; bin < hi; bin++) begin
      sb = bin + s;
      t = top_bins[bin - 1];
      b = (sb >= 1 && sb <= n) ? bottom_bins[sb - 1] : 0;
      if (b != 0 && t != 0) begin
        sum += chi_term(b, t);
        if (sum >= hsca_pkg::CHI_LIMIT) return hsca_pkg::CHI_LIMIT;
      end
    end
    return sum;
  endfunction

  function automatic hsca_pkg::out_word_t best_alignment(int n);
    hsca_pkg::out_word_t r;
    longint unsigned sum;
    longint unsigned best;
    int h;
    r = '0;
    best = 0;
    h = n / 8;
    for (int s = -h; s < h; s++) begin
      sum = shift_cost(s, n);
      if (sum < hsca_pkg::CHI_LIMIT && (!r.found || sum < best)) begin
        best = sum;
        r.best_shift = s[7:0];
        r.min_chi_square = sum[41:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_word(logic [15:0] t, logic [15:0] b, logic last);
    int gap;
    in_data <= '{top_count: t, bottom_count: b, last_bin: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (loaded < STORE_DEPTH) begin
      top_bins[loaded] = t;
      bottom_bins[loaded] = b;
      loaded++;
    end
    if (last) begin
      alignments_due.insert(alignments_due.size(), best_alignment(loaded));
      loaded = 0;
    end
    gap = 0;
    if (!no_idle && $urandom_range(0, 9) < 3)
      gap = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (alignments_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [hsca_pkg::WIN_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == hsca_pkg::REG_WIN_START) win_start = value;
    else win_end = value;
    @(posedge clk);
  endtask

  task automatic set_window(int lo, int hi);
    write_reg(hsca_pkg::REG_WIN_START, lo[hsca_pkg::WIN_BITS-1:0]);
    write_reg(hsca_pkg::REG_WIN_END, hi[hsca_pkg::WIN_BITS-1:0]);
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 20));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1000, 1100));
    endcase
  endfunction

  task automatic send_histogram(int n);
    logic [15:0] t;
    for (int i = 0; i < n; i++) begin
      t = pick_count();
      send_word(t, ($urandom_range(0, 2) == 0) ? t + 16'($urandom_range(0, 6)) : pick_count(),
                i == n - 1);
    end
  endtask

  task automatic test_special_cases();
    wait_idle();
    set_window(1, 1025);
    send_word(16'd5, 16'd5, 1'b1);
    for (int i = 0; i < 8; i++) send_word(16'd1, 16'hFFFF, i == 7);
    for (int i = 0; i < 8; i++) send_word(16'd0, 16'd0, i == 7);
    for (int i = 0; i < 8; i++) send_word(16'hFFFF, 16'd1, i == 7);
    wait_idle();
    set_window(5, 3);
    send_histogram(16);
    wait_idle();
    set_window(1024, 1025);
    send_histogram(9);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_window(1, 24);
    hold_go = 1'b1;
    for (int k = 0; k < 5; k++) send_histogram($urandom_range(1, 12));
    wait_idle();
    no_idle = 1'b1;
    for (int k = 0; k < 6; k++) send_histogram($urandom_range(1, 16));
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_histograms();
    int sent_at_start;
    sent_at_start = words_sent;
    while (words_sent - sent_at_start < 800) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: set_window(1, 1025);
        1: set_window($urandom_range(1, 1024), $urandom_range(1, 1025));
        default: set_window($urandom_range(1, 12), $urandom_range(1, 26));
      endcase
      for (int k = 0; k < 4; k++)
        send_histogram($urandom_range(0, 9) == 0 ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 16));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    win_start = hsca_pkg::WIN_START_RST;
    win_end = hsca_pkg::WIN_END_RST;
    loaded = 0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    hold_left = 0;
    hold_go = 1'b0;
    no_idle = 1'b0;
    cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send_word(16'(1000 + i), 16'(1003 + i), i == 11);
    test_special_cases();
    test_backpressure();
    test_random_histograms();
    wait_idle();
    repeat (200) @(posedge clk);
    $display("Sent %0d words and checked %0d alignment results across window settings,",
             words_sent, results_seen);
    $display("covering empty windows, saturation, zero counts and long back-pressure.");
    if (errors == 0 && alignments_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
